// File: hw/rtl/crp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Color ramp package
// Shared types and codes for the color ramp controller and datapath.
// ----------------------------------------------------------------------------
package crp_pkg;

  localparam int unsigned OffW  = 17;
  localparam int unsigned ChW   = 16;
  localparam int unsigned NumCh = 5;

  // Operation codes.
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // One stop: offset plus red, green, blue, filter and transmit.
  typedef struct packed {
    logic [OffW-1:0]             off;
    logic [NumCh-1:0][ChW-1:0]   ch;
  } crp_entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;
    logic       cnt_clear;
    logic       cnt_inc;
    logic       ptr_load_used;
    logic       ptr_clear;
    logic       ptr_dec;
    logic       ptr_inc;
    logic       mem_rd;
    logic       rd_prev;
    logic       wr_shift;
    logic       wr_new;
    logic       scan_cmp;
    logic       div_init;
    logic       div_step;
    logic       blend;
    logic [2:0] ch_sel;
    logic       res_load_lo;
    logic       out_load;
    logic [1:0] status;
  } crp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       empty;
    logic       ptr_zero;
    logic       new_lt_rd;
    logic       scan_last;
    logic       interp;
  } crp_sts_t;

endpackage

// File: hw/rtl/color_ramp_interpolator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Color ramp interpolator core
// Sorted table of color stops with clear, insert and interpolating lookup.
// ----------------------------------------------------------------------------
// The core keeps up to MAX_STOPS color stops sorted by offset in a single
// stop memory with one write port and one registered read port. Each input
// transaction is one operation: clear resets the stop count; insert walks
// down from the top of the table, moving larger stops up one slot; lookup
// reads every held stop once, then runs a restoring divider for the
// fraction and blends the five channels through one shared multiplier.
// One transaction is processed at a time; a finished result sits in the
// output register so that the next input transaction is taken while the
// previous result still waits.
// ----------------------------------------------------------------------------
module color_ramp_interpolator_core #(
  parameter int unsigned MAX_STOPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [16:0] entry_offset_i,
  input  logic [15:0] entry_red_i,
  input  logic [15:0] entry_green_i,
  input  logic [15:0] entry_blue_i,
  input  logic [15:0] entry_filter_i,
  input  logic [15:0] entry_transmit_i,
  input  logic [15:0] position_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [15:0] out_red_o,
  output logic [15:0] out_green_o,
  output logic [15:0] out_blue_o,
  output logic [15:0] out_filter_o,
  output logic [15:0] out_transmit_o,
  output logic [4:0]  stop_count_o
);

  // Command and status buses between the sequencer and the datapath.
  crp_pkg::crp_cmd_t cmd;
  crp_pkg::crp_sts_t sts;

  // The controller owns the handshakes and the operation sequence.
  crp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the stops, the divider, the blend unit and the
  // output payload registers.
  crp_datapath #(
    .MAX_STOPS (MAX_STOPS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .operation_i      (operation_i),
    .entry_offset_i   (entry_offset_i),
    .entry_red_i      (entry_red_i),
    .entry_green_i    (entry_green_i),
    .entry_blue_i     (entry_blue_i),
    .entry_filter_i   (entry_filter_i),
    .entry_transmit_i (entry_transmit_i),
    .position_i       (position_i),
    .status_o         (status_o),
    .out_red_o        (out_red_o),
    .out_green_o      (out_green_o),
    .out_blue_o       (out_blue_o),
    .out_filter_o     (out_filter_o),
    .out_transmit_o   (out_transmit_o),
    .stop_count_o     (stop_count_o)
  );

endmodule

// File: hw/rtl/crp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Color ramp datapath
// Stop memory, scan registers, serial divider, shared blend multiplier and
// result registers.
// ----------------------------------------------------------------------------
module crp_datapath #(
  parameter int unsigned MAX_STOPS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  crp_pkg::crp_cmd_t   cmd_i,
  output crp_pkg::crp_sts_t   sts_o,
  input  logic [1:0]          operation_i,
  input  logic [16:0]         entry_offset_i,
  input  logic [15:0]         entry_red_i,
  input  logic [15:0]         entry_green_i,
  input  logic [15:0]         entry_blue_i,
  input  logic [15:0]         entry_filter_i,
  input  logic [15:0]         entry_transmit_i,
  input  logic [15:0]         position_i,
  output logic [1:0]          status_o,
  output logic [15:0]         out_red_o,
  output logic [15:0]         out_green_o,
  output logic [15:0]         out_blue_o,
  output logic [15:0]         out_filter_o,
  output logic [15:0]         out_transmit_o,
  output logic [4:0]          stop_count_o
);

  localparam int unsigned CW = $clog2(MAX_STOPS + 1);
  localparam int unsigned IW = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;

  crp_pkg::crp_entry_t mem_q [MAX_STOPS];
  crp_pkg::crp_entry_t rd_q, new_q, lo_q, hi_q;

  logic [CW-1:0]  used_q, ptr_q, ptr_next;
  logic [CW-1:0]  lo_idx_q, hi_idx_q;
  logic           have_hi_q;
  logic [1:0]     op_q;
  logic [15:0]    pos_q;
  logic [17:0]    rem_q;
  logic [17:0]    rem_dbl;
  logic [16:0]    den;
  logic [15:0]    quo_q;
  logic [4:0][15:0] res_q;

  logic [IW-1:0]  wr_addr, rd_addr;
  logic [16:0]    pos_ext;
  logic [15:0]    ch_lo, ch_hi;
  logic signed [16:0] diff;
  logic signed [33:0] prod;
  logic [15:0]    blended;

  logic [1:0]     out_status_q;
  logic [4:0][15:0] out_ch_q;
  logic [4:0]     out_cnt_q;

  assign pos_ext  = {1'b0, pos_q};
  assign ptr_next = ptr_q + CW'(1);
  assign wr_addr  = ptr_q[IW-1:0];
  assign rd_addr  = cmd_i.rd_prev ? IW'(ptr_q - CW'(1)) : ptr_q[IW-1:0];
  assign den      = hi_q.off - lo_q.off;
  assign rem_dbl  = {rem_q[16:0], 1'b0};

  assign ch_lo   = lo_q.ch[cmd_i.ch_sel];
  assign ch_hi   = hi_q.ch[cmd_i.ch_sel];
  assign diff    = $signed({1'b0, ch_hi}) - $signed({1'b0, ch_lo});
  assign prod    = diff * $signed({1'b0, quo_q});
  // Arithmetic shift gives the floor for negative products.
  assign blended = ch_lo + prod[31:16];

  assign sts_o.op        = op_q;
  assign sts_o.full      = (used_q >= CW'(MAX_STOPS));
  assign sts_o.empty     = (used_q == '0);
  assign sts_o.ptr_zero  = (ptr_q == '0);
  assign sts_o.new_lt_rd = (new_q.off < rd_q.off);
  assign sts_o.scan_last = (ptr_next == used_q);
  assign sts_o.interp    = have_hi_q && (hi_idx_q != lo_idx_q) &&
                           (hi_q.off > lo_q.off) && (pos_ext >= lo_q.off);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (cmd_i.cnt_clear) begin
      used_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      used_q <= used_q + CW'(1);
    end
  end

  // Stop memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_shift) begin
      mem_q[wr_addr] <= rd_q;
    end else if (cmd_i.wr_new) begin
      mem_q[wr_addr] <= new_q;
    end
    if (cmd_i.mem_rd) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q      <= operation_i;
      pos_q     <= position_i;
      new_q.off <= entry_offset_i;
      new_q.ch  <= {entry_transmit_i, entry_filter_i, entry_blue_i,
                    entry_green_i, entry_red_i};
      have_hi_q <= 1'b0;
      res_q     <= '0;
    end
    if (cmd_i.ptr_load_used) begin
      ptr_q <= used_q;
    end else if (cmd_i.ptr_clear) begin
      ptr_q <= '0;
    end else if (cmd_i.ptr_dec) begin
      ptr_q <= ptr_q - CW'(1);
    end else if (cmd_i.ptr_inc) begin
      ptr_q <= ptr_next;
    end
    if (cmd_i.scan_cmp) begin
      if ((ptr_q == '0) || (rd_q.off <= pos_ext)) begin
        lo_q     <= rd_q;
        lo_idx_q <= ptr_q;
      end
      if (!have_hi_q && (rd_q.off >= pos_ext)) begin
        hi_q      <= rd_q;
        hi_idx_q  <= ptr_q;
        have_hi_q <= 1'b1;
      end
    end
    if (cmd_i.div_init) begin
      rem_q <= {2'b00, pos_q - lo_q.off[15:0]};
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      if (rem_dbl >= {1'b0, den}) begin
        rem_q <= rem_dbl - {1'b0, den};
        quo_q <= {quo_q[14:0], 1'b1};
      end else begin
        rem_q <= rem_dbl;
        quo_q <= {quo_q[14:0], 1'b0};
      end
    end
    if (cmd_i.res_load_lo) begin
      res_q <= lo_q.ch;
    end else if (cmd_i.blend) begin
      res_q[cmd_i.ch_sel] <= blended;
    end
    if (cmd_i.out_load) begin
      out_status_q <= cmd_i.status;
      out_ch_q     <= res_q;
      out_cnt_q    <= 5'(used_q);
    end
  end

  assign status_o       = out_status_q;
  assign out_red_o      = out_ch_q[0];
  assign out_green_o    = out_ch_q[1];
  assign out_blue_o     = out_ch_q[2];
  assign out_filter_o   = out_ch_q[3];
  assign out_transmit_o = out_ch_q[4];
  assign stop_count_o   = out_cnt_q;

endmodule

// File: hw/rtl/crp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Color ramp controller
// Sequences clear, insert and lookup transactions over the datapath.
// ----------------------------------------------------------------------------
module crp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  crp_pkg::crp_sts_t  sts_i,
  output crp_pkg::crp_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_INS_CHK, S_INS_CMP, S_LK_RD, S_LK_CMP,
    S_LK_EVAL, S_DIV, S_BLEND, S_FIN
  } state_e;

  state_e     state_q, state_d;
  logic [3:0] step_q, step_d;
  logic [1:0] st_q, st_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o        = '0;
    cmd_o.ch_sel = step_q[2:0];
    cmd_o.status = st_q;
    state_d      = state_q;
    step_d       = step_q;
    st_d         = st_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          st_d          = crp_pkg::ST_OK;
          state_d       = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts_i.op)
          crp_pkg::OP_CLEAR: begin
            cmd_o.cnt_clear = 1'b1;
            state_d         = S_FIN;
          end
          crp_pkg::OP_INSERT: begin
            if (sts_i.full) begin
              st_d    = crp_pkg::ST_FULL;
              state_d = S_FIN;
            end else begin
              cmd_o.ptr_load_used = 1'b1;
              state_d             = S_INS_CHK;
            end
          end
          crp_pkg::OP_LOOKUP: begin
            if (sts_i.empty) begin
              st_d    = crp_pkg::ST_EMPTY;
              state_d = S_FIN;
            end else begin
              cmd_o.ptr_clear = 1'b1;
              state_d         = S_LK_RD;
            end
          end
          default: state_d = S_FIN;
        endcase
      end
      S_INS_CHK: begin
        if (sts_i.ptr_zero) begin
          cmd_o.wr_new  = 1'b1;
          cmd_o.cnt_inc = 1'b1;
          state_d       = S_FIN;
        end else begin
          cmd_o.mem_rd  = 1'b1;
          cmd_o.rd_prev = 1'b1;
          state_d       = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (sts_i.new_lt_rd) begin
          cmd_o.wr_shift = 1'b1;
          cmd_o.ptr_dec  = 1'b1;
          state_d        = S_INS_CHK;
        end else begin
          cmd_o.wr_new  = 1'b1;
          cmd_o.cnt_inc = 1'b1;
          state_d       = S_FIN;
        end
      end
      S_LK_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = S_LK_CMP;
      end
      S_LK_CMP: begin
        cmd_o.scan_cmp = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_LK_EVAL;
        end else begin
          cmd_o.ptr_inc = 1'b1;
          state_d       = S_LK_RD;
        end
      end
      S_LK_EVAL: begin
        if (sts_i.interp) begin
          cmd_o.div_init = 1'b1;
          step_d         = '0;
          state_d        = S_DIV;
        end else begin
          cmd_o.res_load_lo = 1'b1;
          state_d           = S_FIN;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 4'd1;
        if (step_q == 4'd15) begin
          state_d = S_BLEND;
        end
      end
      S_BLEND: begin
        cmd_o.blend = 1'b1;
        step_d      = step_q + 4'd1;
        if (step_q == 4'd4) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      st_q        <= crp_pkg::ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: verif/color_ramp_interpolator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Color ramp interpolator core testbench
// Drives clear, insert and lookup transactions with random idling on both
// sides, predicts every result from a model of the sorted stop table and
// checks each output transaction field by field.
// ----------------------------------------------------------------------------
module color_ramp_interpolator_core_tb;

  // The one operation code the package does not name; the core ignores it.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned TableDepth = 16;
  // Cycles without any accepted transaction before the run is abandoned.
  // The limit lies well above the slowest lookup and the long output
  // hold-off, so this leaves a wide margin.
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned HoldOffLen = 400;

  typedef struct {
    logic [1:0]  op;
    logic [16:0] off;
    logic [15:0] ch [crp_pkg::NumCh];
    logic [15:0] pos;
  } ramp_req_t;

  typedef struct {
    logic [1:0]  status;
    logic [15:0] ch [crp_pkg::NumCh];
    logic [4:0]  count;
  } ramp_rsp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  operation_i = crp_pkg::OP_CLEAR;
  logic [16:0] entry_offset_i = '0;
  logic [15:0] entry_red_i = '0;
  logic [15:0] entry_green_i = '0;
  logic [15:0] entry_blue_i = '0;
  logic [15:0] entry_filter_i = '0;
  logic [15:0] entry_transmit_i = '0;
  logic [15:0] position_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [15:0] out_red_o;
  logic [15:0] out_green_o;
  logic [15:0] out_blue_o;
  logic [15:0] out_filter_o;
  logic [15:0] out_transmit_o;
  logic [4:0]  stop_count_o;

  always #1 clk_i = ~clk_i;

  color_ramp_interpolator_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .operation_i, .entry_offset_i,
    .entry_red_i, .entry_green_i, .entry_blue_i, .entry_filter_i,
    .entry_transmit_i, .position_i, .out_valid_o, .out_ready_i, .status_o,
    .out_red_o, .out_green_o, .out_blue_o, .out_filter_o, .out_transmit_o,
    .stop_count_o
  );

  // Transactions waiting to be offered, and results the core still owes us.
  ramp_req_t pending_ops[$];
  ramp_rsp_t owed_colors[$];

  // Output port names of the five channels, for mismatch reports.
  string ch_name [crp_pkg::NumCh] = '{"out_red", "out_green", "out_blue",
                                      "out_filter", "out_transmit"};

  // Shadow copy of the stop table.
  logic [16:0] stop_off [TableDepth];
  logic [15:0] stop_ch  [TableDepth][crp_pkg::NumCh];
  int unsigned stop_used;

  // Idling phase: 0 none, 1 sender idles, 2 receiver stalls, 3 both.
  int unsigned phase;
  bit          running;
  int unsigned errors;
  int unsigned in_done;
  int unsigned out_done;
  int unsigned lookups_done;
  int unsigned drops_seen;
  int unsigned hold_req;
  int unsigned hold_seen;
  int unsigned hold_cnt;
  int unsigned quiet_cycles;
  ramp_req_t   cur_op;

  // Channel blend: lo plus the floor of (hi - lo) * frac / 65536. The
  // arithmetic shift of a signed product rounds toward minus infinity.
  function automatic logic [15:0] mix_channel(logic [15:0] lo, logic [15:0] hi,
                                              logic [15:0] frac);
    longint diff;
    longint prod;
    diff = longint'(hi) - longint'(lo);
    prod = diff * longint'(frac);
    return 16'(longint'(lo) + (prod >>> 16));
  endfunction

  // Applies one operation to the shadow table and returns the result.
  task automatic apply_ramp_op(input ramp_req_t r, output ramp_rsp_t e);
    int unsigned at;
    int unsigned lo;
    int unsigned hi;
    bit          have_hi;
    longint      quot;
    logic [15:0] frac;
    e.status = crp_pkg::ST_OK;
    foreach (e.ch[c]) e.ch[c] = '0;
    case (r.op)
      crp_pkg::OP_CLEAR: stop_used = 0;
      crp_pkg::OP_INSERT: begin
        if (stop_used >= TableDepth) begin
          e.status = crp_pkg::ST_FULL;
        end else begin
          // New stop goes after every stop with an equal or lower offset.
          at = stop_used;
          for (int i = 0; i < stop_used; i++) begin
            if (r.off < stop_off[i]) begin
              at = i;
              break;
            end
          end
          for (int i = stop_used; i > at; i--) begin
            stop_off[i] = stop_off[i-1];
            stop_ch[i] = stop_ch[i-1];
          end
          stop_off[at] = r.off;
          foreach (r.ch[c]) stop_ch[at][c] = r.ch[c];
          stop_used++;
        end
      end
      crp_pkg::OP_LOOKUP: begin
        if (stop_used == 0) begin
          e.status = crp_pkg::ST_EMPTY;
        end else begin
          lo = 0;
          hi = 0;
          have_hi = 0;
          for (int i = 0; i < stop_used; i++) begin
            if (stop_off[i] <= r.pos) lo = i;
            if (!have_hi && stop_off[i] >= r.pos) begin
              hi = i;
              have_hi = 1;
            end
          end
          foreach (e.ch[c]) e.ch[c] = stop_ch[lo][c];
          // Equal offsets or a single bracketing stop keep the lower color.
          if (have_hi && hi != lo && stop_off[hi] > stop_off[lo] &&
              r.pos >= stop_off[lo]) begin
            quot = (longint'(r.pos - stop_off[lo]) << 16) /
                   longint'(stop_off[hi] - stop_off[lo]);
            frac = (quot > 65535) ? 16'hffff : 16'(quot);
            foreach (e.ch[c]) e.ch[c] = mix_channel(stop_ch[lo][c], stop_ch[hi][c], frac);
          end
        end
      end
      default: ;
    endcase
    e.count = 5'(stop_used);
  endtask

  // Sender: offers the next pending transaction and holds it until taken.
  always @(posedge clk_i) begin : sender
    ramp_rsp_t e;
    ramp_req_t nxt;
    bit        idle;
    if (running) begin
      if (in_valid_i && in_ready_o) begin
        apply_ramp_op(cur_op, e);
        owed_colors.push_back(e);
        in_done++;
        if (cur_op.op == crp_pkg::OP_LOOKUP) lookups_done++;
        if (e.status == crp_pkg::ST_FULL) drops_seen++;
      end
      if (!in_valid_i || in_ready_o) begin
        idle = (phase == 1 && $urandom_range(99) < 77) ||
               (phase == 3 && $urandom_range(99) < 21);
        if (pending_ops.size() > 0 && !idle) begin
          nxt = pending_ops.pop_front();
          cur_op <= nxt;
          operation_i <= nxt.op;
          entry_offset_i <= nxt.off;
          entry_red_i <= nxt.ch[0];
          entry_green_i <= nxt.ch[1];
          entry_blue_i <= nxt.ch[2];
          entry_filter_i <= nxt.ch[3];
          entry_transmit_i <= nxt.ch[4];
          position_i <= nxt.pos;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each accepted result and picks the next ready level.
  always @(posedge clk_i) begin : receiver
    ramp_rsp_t e;
    logic [15:0] got [crp_pkg::NumCh];
    bit stall;
    if (running) begin
      if (out_valid_o && out_ready_i) begin
        out_done++;
        got = '{out_red_o, out_green_o, out_blue_o, out_filter_o, out_transmit_o};
        if (owed_colors.size() == 0) begin
          $error("result with no transaction outstanding");
          errors++;
        end else begin
          e = owed_colors.pop_front();
          if (status_o !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, status_o);
            errors++;
          end
          foreach (got[c]) begin
            if (got[c] !== e.ch[c]) begin
              $error("%s: expected %0h, got %0h", ch_name[c], e.ch[c], got[c]);
              errors++;
            end
          end
          if (stop_count_o !== e.count) begin
            $error("stop_count: expected %0d, got %0d", e.count, stop_count_o);
            errors++;
          end
        end
      end
      // A long hold-off lets the core fill up and back-pressure its input.
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_cnt = HoldOffLen;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        stall = 1;
      end else begin
        stall = (phase == 2 && $urandom_range(99) < 77) ||
                (phase == 3 && $urandom_range(99) < 21);
      end
      out_ready_i <= !stall;
    end
  end

  // Watchdog on cycles with no transaction on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !running)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic ramp_req_t make_op(logic [1:0] op, logic [16:0] off,
                                        logic [15:0] pos);
    ramp_req_t r;
    r.op = op;
    r.off = off;
    foreach (r.ch[c]) r.ch[c] = 16'($urandom);
    r.pos = pos;
    return r;
  endfunction

  // Random offset: mostly inside [0, 1.0], sometimes from a small pool so
  // that equal offsets occur, now and then any 17-bit value.
  function automatic logic [16:0] pick_offset();
    case ($urandom_range(9))
      0, 1:    return 17'($urandom_range(4) * 16384);
      2:       return 17'($urandom);
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  task automatic queue_random(int unsigned n);
    int unsigned added;
    int unsigned k;
    logic [16:0] offs[$];
    added = 0;
    while (added < n) begin
      if ($urandom_range(9) == 0) begin
        pending_ops.push_back(make_op(2'($urandom), 17'($urandom), 16'($urandom)));
        added++;
      end else begin
        // Well-formed ramp: usually a clear, a run of inserts, then some lookups.
        offs.delete();
        if ($urandom_range(3) != 0) begin
          pending_ops.push_back(make_op(crp_pkg::OP_CLEAR, 17'($urandom),
                                        16'($urandom)));
          added++;
        end
        k = ($urandom_range(5) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 6);
        repeat (k) begin
          offs.push_back(pick_offset());
          pending_ops.push_back(make_op(crp_pkg::OP_INSERT, offs[$], 16'($urandom)));
          added++;
        end
        repeat ($urandom_range(2, 8)) begin
          case ($urandom_range(3))
            0: k = 16'(offs[$urandom_range(offs.size() - 1)]);
            1: k = $urandom_range(1) ? 16'hffff : 16'h0000;
            default: k = $urandom_range(65535);
          endcase
          pending_ops.push_back(make_op(crp_pkg::OP_LOOKUP, 17'($urandom), 16'(k)));
          added++;
        end
      end
    end
  endtask

  task automatic drain();
    while (pending_ops.size() > 0 || owed_colors.size() > 0 || in_valid_i)
      @(posedge clk_i);
  endtask

  initial begin
    stop_used = 0;
    errors = 0;
    phase = 0;
    hold_req = 0;
    hold_seen = 0;
    hold_cnt = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    running = 1;

    // Directed: empty lookup, extreme stops, equal offsets, position below
    // the first stop, an offset above 1.0 and the unused operation code.
    pending_ops.push_back(make_op(crp_pkg::OP_LOOKUP, '0, 16'h8000));
    pending_ops.push_back(make_op(OP_UNUSED, 17'h1ffff, 16'hffff));
    pending_ops.push_back(make_op(crp_pkg::OP_INSERT, 17'd0, '0));
    pending_ops[$].ch = '{16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff};
    pending_ops.push_back(make_op(crp_pkg::OP_INSERT, 17'd65536, '0));
    pending_ops[$].ch = '{16'h0, 16'h0, 16'h0, 16'h0, 16'h0};
    pending_ops.push_back(make_op(crp_pkg::OP_LOOKUP, '0, 16'h0000));
    pending_ops.push_back(make_op(crp_pkg::OP_LOOKUP, '0, 16'hffff));
    pending_ops.push_back(make_op(crp_pkg::OP_LOOKUP, '0, 16'h8000));
    pending_ops.push_back(make_op(crp_pkg::OP_INSERT, 17'd32768, '0));
    pending_ops.push_back(make_op(crp_pkg::OP_INSERT, 17'd32768, '0));
    pending_ops.push_back(make_op(crp_pkg::OP_LOOKUP, '0, 16'd32768));
    pending_ops.push_back(make_op(crp_pkg::OP_LOOKUP, '0, 16'd40000));
    pending_ops.push_back(make_op(crp_pkg::OP_CLEAR, '0, '0));
    pending_ops.push_back(make_op(crp_pkg::OP_INSERT, 17'd1000, '0));
    pending_ops.push_back(make_op(crp_pkg::OP_INSERT, 17'h1ffff, '0));
    pending_ops.push_back(make_op(crp_pkg::OP_LOOKUP, '0, 16'd5));
    pending_ops.push_back(make_op(crp_pkg::OP_LOOKUP, '0, 16'd30000));
    pending_ops.push_back(make_op(OP_UNUSED, '0, '0));
    pending_ops.push_back(make_op(crp_pkg::OP_CLEAR, 17'h1ffff, 16'hffff));
    pending_ops.push_back(make_op(crp_pkg::OP_LOOKUP, '0, '0));
    drain();

    for (int p = 0; p < 4; p++) begin
      phase = p;
      queue_random(110);
      if (p == 0) begin
        // Hold the output off while inputs keep arriving.
        repeat (20) @(posedge clk_i);
        hold_req++;
      end
      drain();
    end
    repeat (100) @(posedge clk_i);

    $display("Ran %0d transactions in, %0d results out: %0d lookups, %0d inserts",
             in_done, out_done, lookups_done, drops_seen);
    $display("dropped on a full table, over four idling phases and one long hold-off.");
    if (errors == 0 && owed_colors.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
